>>> hdl/twc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_pkg
// Shared constants, codes and types of the textured wall column block.
// ----------------------------------------------------------------------------
package twc_pkg;

    // texture store geometry
    localparam int TEX_SIZE    = 64;
    localparam int TEX_B       = $clog2(TEX_SIZE);
    localparam int NUM_FACES   = 4;
    localparam int FACE_W      = 2;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = NUM_FACES * TEX_SIZE * TEX_SIZE;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // field widths
    localparam int KIND_W  = 2;
    localparam int SIGNS_W = 2;
    localparam int POS_IW  = 24;
    localparam int DIR_W   = 18;
    localparam int DIST_W  = 24;
    localparam int LH_W    = 16;
    localparam int ROW_W   = 12;
    localparam int ADDR_W  = 14;
    localparam int COLOR_W = 32;
    localparam int SH_W    = 12;

    localparam logic [SH_W-1:0] SH_RESET = 12'd480;

    // column arithmetic
    localparam int POS_W   = 40;
    localparam int STEP_W  = 24;
    localparam int START_W = 18;
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
    localparam logic [COLOR_W-1:0] DARK_MASK = 32'd8355711;

    // hit product, wide enough for the fraction bits of the hit point
    localparam int P_W = (2 * FRAC_BITS > DIST_W + DIR_W + 1) ?
                         2 * FRAC_BITS : DIST_W + DIR_W + 1;

    // step divider: (TEX_SIZE << FRAC_BITS) / line_height, one bit a cycle
    localparam int QW    = FRAC_BITS + TEX_B + 1;
    localparam int CNT_W = $clog2(QW);
    localparam int QCW   = (QW > STEP_W) ? QW : STEP_W;
    localparam logic [QW-1:0] DIV_NUM = QW'(TEX_SIZE) << FRAC_BITS;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // item kinds
    localparam logic [KIND_W-1:0] K_TEXEL  = 2'd0;
    localparam logic [KIND_W-1:0] K_COLUMN = 2'd1;
    localparam logic [KIND_W-1:0] K_PIXEL  = 2'd2;
    localparam logic [KIND_W-1:0] K_NONE   = 2'd3;

    // texture faces
    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
    localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
    localparam logic [FACE_W-1:0] FACE_WEST  = 2'd2;
    localparam logic [FACE_W-1:0] FACE_EAST  = 2'd3;

    // classified command passed from front to back
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [FACE_W-1:0]        face;
        logic                     dark;
        logic                     mirror;
        logic [FRAC_BITS-1:0]     pos_frac;
        logic signed [DIR_W-1:0]  dir;
        logic [DIST_W-1:0]        wall_dist;
        logic [LH_W-1:0]          line_height;
        logic signed [START_W-1:0] start_row;
        logic [ADDR_W-1:0]        texel_addr;
        logic [COLOR_W-1:0]       texel_color;
    } t_cmd;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

>>> hdl/twc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface twc_in_if;
    import twc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic                     side;
    logic [SIGNS_W-1:0]       step_signs;
    logic [POS_IW-1:0]        pos_x;
    logic [POS_IW-1:0]        pos_y;
    logic signed [DIR_W-1:0]  ray_dir_x;
    logic signed [DIR_W-1:0]  ray_dir_y;
    logic [DIST_W-1:0]        wall_dist;
    logic [LH_W-1:0]          line_height;
    logic [ROW_W-1:0]         draw_start;
    logic [ADDR_W-1:0]        texel_addr;
    logic [COLOR_W-1:0]       texel_color;

    modport source (output valid, kind, side, step_signs, pos_x, pos_y, ray_dir_x,
                    ray_dir_y, wall_dist, line_height, draw_start, texel_addr,
                    texel_color, input ready);
    modport sink   (input valid, kind, side, step_signs, pos_x, pos_y, ray_dir_x,
                    ray_dir_y, wall_dist, line_height, draw_start, texel_addr,
                    texel_color, output ready);
endinterface

interface twc_out_if;
    import twc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [FACE_W-1:0]  face;

    modport source (output valid, pixel_color, face, input ready);
    modport sink   (input valid, pixel_color, face, output ready);
endinterface

interface twc_cfg_if;
    import twc_pkg::*;
    logic            valid;
    logic            ready;
    logic [SH_W-1:0] screen_height;

    modport source (output valid, screen_height, input ready);
    modport sink   (input valid, screen_height, output ready);
endinterface
`default_nettype wire

>>> hdl/twc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_front
// Accepts input transactions, holds screen_height and classifies each item
// into a queue command (face, mirror, hit operands, start row).
// ----------------------------------------------------------------------------
module twc_front
    import twc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    twc_in_if.sink     i_in,
    twc_cfg_if.sink    i_cfg,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [SH_W-1:0] r_screen_height;

    // configuration register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= SH_RESET;
        end else if (i_cfg.valid) begin
            r_screen_height <= i_cfg.screen_height;
        end
    end

    // accept while the queue has room; unknown kinds are dropped here
    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full && (i_in.kind != K_NONE);

    // classification
    always_comb begin
        o_cmd             = '0;
        o_cmd.kind        = i_in.kind;
        o_cmd.dark        = i_in.side;
        if (i_in.side) begin
            o_cmd.face     = i_in.step_signs[1] ? FACE_SOUTH : FACE_NORTH;
            o_cmd.pos_frac = i_in.pos_x[FRAC_BITS-1:0];
            o_cmd.dir      = i_in.ray_dir_x;
            o_cmd.mirror   = i_in.ray_dir_y[DIR_W-1];
        end else begin
            o_cmd.face     = i_in.step_signs[0] ? FACE_EAST : FACE_WEST;
            o_cmd.pos_frac = i_in.pos_y[FRAC_BITS-1:0];
            o_cmd.dir      = i_in.ray_dir_y;
            o_cmd.mirror   = !i_in.ray_dir_x[DIR_W-1] && (i_in.ray_dir_x != '0);
        end
        o_cmd.wall_dist   = i_in.wall_dist;
        o_cmd.line_height = i_in.line_height;
        // centred start row: draw_start - screen_height/2 + line_height/2
        o_cmd.start_row   = $signed({(START_W-ROW_W)'(0), i_in.draw_start})
                          - $signed({(START_W-SH_W+1)'(0), r_screen_height[SH_W-1:1]})
                          + $signed({(START_W-LH_W+1)'(0), i_in.line_height[LH_W-1:1]});
        o_cmd.texel_addr  = i_in.texel_addr;
        o_cmd.texel_color = i_in.texel_color;
    end

endmodule
`default_nettype wire

>>> hdl/twc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module twc_queue
    import twc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_cmd       i_cmd,
    input  wire logic  i_pop,
    output t_cmd       o_head,
    output t_q_status  o_status
);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count,  n_count;
    logic              push_ok, pop_ok;

    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_head         = r_entry[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

>>> hdl/twc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_back
// Executes queued commands: texel writes into the texture store, column
// setup through a bit-serial step divider, and pixel reads with darkening.
// ----------------------------------------------------------------------------
module twc_back
    import twc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_q_status  i_q_status,
    input  t_cmd       i_head,
    output logic       o_pop,
    twc_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_POS  = 3'd3;
    localparam logic [2:0] S_PIX  = 3'd4;

    logic [2:0] r_state, n_state;

    // texture store
    logic [COLOR_W-1:0] r_store [STORE_DEPTH];
    logic [COLOR_W-1:0] r_rd_data;

    // column state
    logic [FACE_W-1:0]  r_face;
    logic [TEX_B-1:0]   r_tex_x;
    logic               r_dark;
    logic [POS_W-1:0]   r_tex_pos;
    logic [STEP_W-1:0]  r_tex_step;

    // column setup operands
    logic [FACE_W-1:0]         r_c_face;
    logic                      r_c_dark;
    logic                      r_c_mirror;
    logic [FRAC_BITS-1:0]      r_c_pos_frac;
    logic [LH_W-1:0]           r_c_lh;
    logic signed [START_W-1:0] r_c_start;
    logic signed [P_W-1:0]     r_prod;

    // divider
    logic [LH_W-1:0]   r_rem;
    logic [QW-1:0]     r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [LH_W:0]     div_trial;
    logic              div_bit;
    logic [QCW-1:0]    quo_ext;
    logic              step_sat;

    // hit fraction and texture column
    logic [FRAC_BITS-1:0] hit_frac;
    logic [TEX_B-1:0]     tex_x;

    // start position product
    logic signed [START_W+STEP_W:0] pos_prod;

    // output register
    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic [FACE_W-1:0]  r_out_face;
    logic               r_pix_dark;
    logic [FACE_W-1:0]  r_pix_face;
    logic               out_free;

    logic [STORE_AW-1:0] rd_addr;
    logic                head_texel, head_column, head_pixel;

    assign out_free    = !r_out_valid || o_out.ready;
    assign head_texel  = (i_head.kind == K_TEXEL);
    assign head_column = (i_head.kind == K_COLUMN);
    assign head_pixel  = (i_head.kind == K_PIXEL);
    assign o_pop       = (r_state == S_IDLE) && !i_q_status.empty;
    assign rd_addr     = {r_face, r_tex_pos[FRAC_BITS+TEX_B-1:FRAC_BITS], r_tex_x};

    // one restoring division step
    assign div_trial = {r_rem, DIV_NUM[r_cnt]};
    assign div_bit   = (div_trial >= {1'b0, r_c_lh});

    // step saturation, zero line height included
    assign quo_ext  = QCW'(r_quo);
    assign step_sat = (r_c_lh == '0) || (quo_ext > QCW'(STEP_MAX));

    // texture column from the fraction of the hit point
    assign hit_frac = r_c_pos_frac + r_prod[2*FRAC_BITS-1:FRAC_BITS];
    assign tex_x    = r_c_mirror ? ~hit_frac[FRAC_BITS-1:FRAC_BITS-TEX_B]
                                 : hit_frac[FRAC_BITS-1:FRAC_BITS-TEX_B];

    assign pos_prod = r_c_start * $signed({1'b0, r_tex_step});

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    if (head_column) begin
                        n_state = S_DIV;
                    end else if (head_pixel) begin
                        n_state = S_PIX;
                    end
                end
            end
            S_DIV:   n_state = (r_cnt == '0) ? S_FIN : S_DIV;
            S_FIN:   n_state = S_POS;
            S_POS:   n_state = S_IDLE;
            S_PIX:   n_state = out_free ? S_IDLE : S_PIX;
            default: n_state = S_IDLE;
        endcase
    end

    // control and column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_face      <= '0;
            r_tex_x     <= '0;
            r_dark      <= 1'b0;
            r_tex_pos   <= '0;
            r_tex_step  <= '0;
        end else begin
            r_state <= n_state;
            // set on load, cleared once taken
            if ((r_state == S_PIX) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop && head_pixel) begin
                r_tex_pos <= r_tex_pos + POS_W'(r_tex_step);
            end
            if (r_state == S_FIN) begin
                r_face     <= r_c_face;
                r_dark     <= r_c_dark;
                r_tex_x    <= tex_x;
                r_tex_step <= step_sat ? STEP_MAX : quo_ext[STEP_W-1:0];
            end
            if (r_state == S_POS) begin
                r_tex_pos <= pos_prod[POS_W-1:0];
            end
        end
    end

    // column operands, hit product and divider
    always_ff @(posedge i_clk) begin
        if (o_pop && head_column) begin
            r_c_face     <= i_head.face;
            r_c_dark     <= i_head.dark;
            r_c_mirror   <= i_head.mirror;
            r_c_pos_frac <= i_head.pos_frac;
            r_c_lh       <= i_head.line_height;
            r_c_start    <= i_head.start_row;
            r_prod       <= $signed({1'b0, i_head.wall_dist}) * i_head.dir;
            r_rem        <= '0;
            r_quo        <= '0;
            r_cnt        <= CNT_W'(QW - 1);
        end else if (r_state == S_DIV) begin
            r_rem <= div_bit ? LH_W'(div_trial - {1'b0, r_c_lh}) : div_trial[LH_W-1:0];
            r_quo <= {r_quo[QW-2:0], div_bit};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // texture store write and read ports
    always_ff @(posedge i_clk) begin
        if (o_pop && head_texel && ({1'b0, i_head.texel_addr} < STORE_DEPTH)) begin
            r_store[STORE_AW'(i_head.texel_addr)] <= i_head.texel_color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && head_pixel) begin
            r_rd_data  <= r_store[rd_addr];
            r_pix_dark <= r_dark;
            r_pix_face <= r_face;
        end
    end

    // output payload, darkened on y-sides
    always_ff @(posedge i_clk) begin
        if ((r_state == S_PIX) && out_free) begin
            r_out_color <= r_pix_dark ? ((r_rd_data >> 1) & DARK_MASK) : r_rd_data;
            r_out_face  <= r_pix_face;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_color = r_out_color;
    assign o_out.face        = r_out_face;

endmodule
`default_nettype wire

>>> hdl/textured_wall_column.sv
`default_nettype none
// ----------------------------------------------------------------------------
// textured_wall_column
// Texture-maps one wall column of a raycaster from a four-face texture store.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready input transactions. kind 0 writes one texel, kind 1
//           starts a column (no result), kind 2 requests the next row pixel,
//           kind 3 is accepted and dropped.
//   o_out : valid/ready result transactions, one per kind 2 item, in order.
//   i_cfg : valid/ready write of screen_height, always ready; write it only
//           while the block is idle.
// Timing:
//   A pixel result is loaded into the output register after its item has passed
//   the command queue and the store read register; the back end takes the next
//   item only once the pixel is loaded. A texel write is done when it is popped.
//   A column start runs the bit-serial step divider and then the finish and
//   start-position states; items behind it wait in the 4-entry command queue.
// Reset: synchronous, active low; screen_height returns to 480 and column
//   state to zero. The texture store is not cleared: write before reading.
// Stall: a result waits in the output register; the back end stops at the next
//   pixel request, the queue fills and i_in.ready drops when it is full.
// ----------------------------------------------------------------------------
module textured_wall_column
    import twc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    twc_in_if.sink     i_in,
    twc_cfg_if.sink    i_cfg,
    twc_out_if.source  o_out
);

    t_q_status q_status;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;

    // accept and classify
    twc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (i_cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // decoupling queue
    twc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // execute
    twc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head_cmd),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

>>> hdl/twc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_checker
// Port-level checks of the textured wall column, bound to the top level.
// ----------------------------------------------------------------------------
module twc_checker
    import twc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic [KIND_W-1:0]  i_in_kind,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [COLOR_W-1:0] i_out_color,
    input wire logic [FACE_W-1:0]  i_out_face
);

    logic [3:0] r_pending, n_pending;
    logic       pix_in, pix_out;

    // pixel requests accepted but not yet delivered
    assign pix_in  = i_in_valid && i_in_ready && (i_in_kind == K_PIXEL);
    assign pix_out = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending;
        if (pix_in && !pix_out) begin
            n_pending = r_pending + 1'b1;
        end else if (pix_out && !pix_in) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // no result without an outstanding pixel request
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != '0))
        else $error("result without a pending pixel request");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_color) && $stable(i_out_face)))
        else $error("result payload changed while stalled");

endmodule

bind textured_wall_column twc_checker u_twc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_kind   (i_in.kind),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_color (o_out.pixel_color),
    .i_out_face  (o_out.face)
);
`default_nettype wire

>>> tb/sv/tb_textured_wall_column.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_textured_wall_column
// Self-checking testbench of the textured wall column block. A behavioral
// predictor tracks the texture store, the screen height and the column
// state, and works out each pixel as its request is accepted. Directed
// columns cover every face, both mirror cases, zero and extreme line heights
// and negative start rows. Random phases then run columns with pixel runs
// under several sender and receiver idling mixes, with a long output stall.
// Pixels only ever read texels that were written before.
// ----------------------------------------------------------------------------
module tb_textured_wall_column;
    import twc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 300;

    // one input transaction
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic                    side;
        logic [SIGNS_W-1:0]      step_signs;
        logic [POS_IW-1:0]       pos_x;
        logic [POS_IW-1:0]       pos_y;
        logic signed [DIR_W-1:0] ray_dir_x;
        logic signed [DIR_W-1:0] ray_dir_y;
        logic [DIST_W-1:0]       wall_dist;
        logic [LH_W-1:0]         line_height;
        logic [ROW_W-1:0]        draw_start;
        logic [ADDR_W-1:0]       texel_addr;
        logic [COLOR_W-1:0]      texel_color;
    } t_item;

    // one expected pixel
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [FACE_W-1:0]  face;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;

    twc_in_if  in_if ();
    twc_out_if out_if ();
    twc_cfg_if cfg_if ();

    textured_wall_column dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // predicted block state
    logic [COLOR_W-1:0] texel_mem [STORE_DEPTH];
    bit                 texel_written [STORE_DEPTH];
    logic [SH_W-1:0]    model_height;
    logic [FACE_W-1:0]  col_face;
    logic [TEX_B-1:0]   col_tex_x;
    logic               col_dark;
    logic [POS_W-1:0]   tex_pos;
    logic [STEP_W-1:0]  tex_step;

    t_pixel pending_pixels[$];
    int     error_count   = 0;
    int     snd_idle_pct  = 0;
    int     rcv_stall_pct = 0;
    int     hold_request  = 0;
    int     hold_left     = 0;

    // column start: face, texture column, step and start position
    function automatic void apply_column_start(input t_item it);
        logic [POS_IW-1:0]       pos;
        logic signed [DIR_W-1:0] dir;
        longint                  prod;
        longint                  hit;
        longint                  quot;
        longint                  start_row;
        logic [FRAC_BITS-1:0]    frac;
        logic [TEX_B-1:0]        tx;
        if (it.side)
            col_face = it.step_signs[1] ? FACE_SOUTH : FACE_NORTH;
        else
            col_face = it.step_signs[0] ? FACE_EAST : FACE_WEST;
        col_dark = it.side;

        // fraction of the hit point, floored
        pos  = it.side ? it.pos_x : it.pos_y;
        dir  = it.side ? it.ray_dir_x : it.ray_dir_y;
        prod = longint'(it.wall_dist) * longint'(dir);
        hit  = longint'(pos) + (prod >>> FRAC_BITS);
        frac = hit[FRAC_BITS-1:0];
        tx   = frac[FRAC_BITS-1 -: TEX_B];
        if ((!it.side && it.ray_dir_x > 0) || (it.side && it.ray_dir_y < 0))
            tx = TEX_B'(TEX_SIZE - 1 - int'(tx));
        col_tex_x = tx;

        // step, saturated on zero height
        if (it.line_height == '0) begin
            tex_step = STEP_MAX;
        end else begin
            quot = (longint'(TEX_SIZE) << FRAC_BITS) / longint'(it.line_height);
            tex_step = (quot > longint'(STEP_MAX)) ? STEP_MAX : STEP_W'(quot);
        end

        start_row = longint'(it.draw_start) - longint'(model_height / 2)
                  + longint'(it.line_height / 2);
        tex_pos = POS_W'(start_row * longint'(tex_step));
    endfunction

    function automatic logic [STORE_AW-1:0] next_texel_addr();
        return {col_face, tex_pos[FRAC_BITS +: TEX_B], col_tex_x};
    endfunction

    // pixel of the current row, then advance one step
    function automatic t_pixel render_pixel();
        t_pixel px;
        px.color = texel_mem[next_texel_addr()];
        if (col_dark)
            px.color = (px.color >> 1) & DARK_MASK;
        px.face = col_face;
        tex_pos = tex_pos + POS_W'(tex_step);
        return px;
    endfunction

    function automatic t_item random_item(input logic [KIND_W-1:0] k);
        t_item it;
        it.kind        = k;
        it.side        = 1'($urandom);
        it.step_signs  = SIGNS_W'($urandom);
        it.pos_x       = POS_IW'($urandom);
        it.pos_y       = POS_IW'($urandom);
        it.ray_dir_x   = DIR_W'($urandom);
        it.ray_dir_y   = DIR_W'($urandom);
        it.wall_dist   = DIST_W'($urandom);
        it.line_height = LH_W'($urandom);
        it.draw_start  = ROW_W'($urandom);
        it.texel_addr  = ADDR_W'($urandom);
        it.texel_color = COLOR_W'($urandom);
        return it;
    endfunction

    // column with mostly realistic heights and distances
    function automatic t_item make_column();
        t_item it;
        int    r;
        it = random_item(K_COLUMN);
        r  = $urandom_range(99);
        if (r < 5)
            it.line_height = '0;
        else if (r < 45)
            it.line_height = LH_W'($urandom_range(1, 64));
        else if (r < 80)
            it.line_height = LH_W'($urandom_range(65, 1000));
        if ($urandom_range(1))
            it.wall_dist = DIST_W'($urandom_range(0, 1 << 19));
        return it;
    endfunction

    // drive one transaction and update the predictor when it is taken
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.kind        = it.kind;
        in_if.side        = it.side;
        in_if.step_signs  = it.step_signs;
        in_if.pos_x       = it.pos_x;
        in_if.pos_y       = it.pos_y;
        in_if.ray_dir_x   = it.ray_dir_x;
        in_if.ray_dir_y   = it.ray_dir_y;
        in_if.wall_dist   = it.wall_dist;
        in_if.line_height = it.line_height;
        in_if.draw_start  = it.draw_start;
        in_if.texel_addr  = it.texel_addr;
        in_if.texel_color = it.texel_color;
        in_if.valid       = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        case (it.kind)
            K_TEXEL: begin
                texel_mem[it.texel_addr]     = it.texel_color;
                texel_written[it.texel_addr] = 1'b1;
            end
            K_COLUMN: apply_column_start(it);
            K_PIXEL:  pending_pixels.push_back(render_pixel());
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // a pixel whose texel was never written gets that texel first
    task automatic issue(input t_item it);
        t_item               fill;
        logic [STORE_AW-1:0] a;
        if (it.kind == K_PIXEL) begin
            a = next_texel_addr();
            if (!texel_written[a]) begin
                fill = random_item(K_TEXEL);
                fill.texel_addr = ADDR_W'(a);
                send_item(fill);
            end
        end
        send_item(it);
    endtask

    task automatic wait_idle();
        in_if.valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_height(input logic [SH_W-1:0] h);
        cfg_if.screen_height = h;
        cfg_if.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        model_height = h;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic issue_column_run(input t_item col, input int n_pix);
        issue(col);
        repeat (n_pix) issue(random_item(K_PIXEL));
    endtask

    // directed corners at the reset screen height
    task automatic test_directed_cases();
        t_item it;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;

        // store corners, then a pixel from the reset column state
        it = random_item(K_TEXEL);
        it.texel_addr  = '0;
        it.texel_color = '1;
        issue(it);
        it = random_item(K_TEXEL);
        it.texel_addr  = '1;
        it.texel_color = '0;
        issue(it);
        issue(random_item(K_PIXEL));

        // west face, no mirror, start row zero
        it = random_item(K_COLUMN);
        it.side = 1'b0; it.step_signs = 2'b00;
        it.pos_y = '0; it.ray_dir_y = '0; it.ray_dir_x = 18'h3FFFF;
        it.wall_dist = '0; it.line_height = 16'd64; it.draw_start = 12'd208;
        issue_column_run(it, 2);

        // east face mirrored, all-ones position and distance, height one
        it = random_item(K_COLUMN);
        it.side = 1'b0; it.step_signs = 2'b01;
        it.ray_dir_x = 18'h1FFFF; it.ray_dir_y = 18'h20000;
        it.pos_y = '1; it.wall_dist = '1; it.line_height = 16'd1; it.draw_start = '0;
        issue_column_run(it, 2);

        // south face, zero height saturates the step
        it = random_item(K_COLUMN);
        it.side = 1'b1; it.step_signs = 2'b10;
        it.ray_dir_x = 18'h1FFFF; it.ray_dir_y = 18'h1FFFF;
        it.pos_x = '1; it.wall_dist = '1; it.line_height = '0; it.draw_start = '1;
        issue_column_run(it, 2);

        // north face mirrored, tallest line, positive start
        it = random_item(K_COLUMN);
        it.side = 1'b1; it.step_signs = 2'b00;
        it.ray_dir_x = 18'h20000; it.ray_dir_y = 18'h3FFFF;
        it.pos_x = 24'h008000; it.wall_dist = 24'h010000;
        it.line_height = '1; it.draw_start = '0;
        issue_column_run(it, 2);

        // zero x direction on an x-side is not mirrored
        it = random_item(K_COLUMN);
        it.side = 1'b0; it.step_signs = 2'b11;
        it.ray_dir_x = '0; it.ray_dir_y = 18'h10000;
        it.pos_y = 24'h00FFFF; it.wall_dist = 24'd1;
        it.line_height = 16'd2; it.draw_start = '1;
        issue_column_run(it, 2);

        // zero y direction on a y-side is not mirrored
        it = random_item(K_COLUMN);
        it.side = 1'b1; it.step_signs = 2'b11;
        it.ray_dir_y = '0; it.line_height = 16'd480;
        issue_column_run(it, 2);

        // unknown kind is dropped
        issue(random_item(K_NONE));
    endtask

    // random columns with pixel runs, plus texel writes, noise and stray pixels
    task automatic test_random_phase(input logic [SH_W-1:0] h, input int snd_pct,
                                     input int rcv_pct, input int n_items);
        int sent;
        int r;
        int n_pix;
        wait_idle();
        write_height(h);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 75) begin
                n_pix = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
                issue_column_run(make_column(), n_pix);
                sent += 1 + n_pix;
            end else if (r < 88) begin
                issue(random_item(K_TEXEL));
                sent++;
            end else if (r < 94) begin
                issue(random_item(K_NONE));
            end else begin
                issue(random_item(K_PIXEL));
                sent++;
            end
        end
    endtask

    // long output stall while items keep coming, so the input backs up
    task automatic test_output_backpressure();
        wait_idle();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        @(negedge i_clk);
        issue_column_run(make_column(), 40);
    endtask

    // receiver ready, with requested hold-off stretches
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_if.ready = 1'b0;
            hold_left--;
        end else begin
            out_if.ready = ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // compare each result transaction with the oldest expected pixel
    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel: pixel_color %h face %0d",
                       out_if.pixel_color, out_if.face);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (out_if.pixel_color !== exp_px.color) begin
                    $error("pixel_color mismatch: expected %h, actual %h",
                           exp_px.color, out_if.pixel_color);
                    error_count++;
                end
                if (out_if.face !== exp_px.face) begin
                    $error("face mismatch: expected %0d, actual %0d",
                           exp_px.face, out_if.face);
                    error_count++;
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("textured_wall_column regression: fail");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.kind           = K_TEXEL;
        in_if.side           = 1'b0;
        in_if.step_signs     = '0;
        in_if.pos_x          = '0;
        in_if.pos_y          = '0;
        in_if.ray_dir_x      = '0;
        in_if.ray_dir_y      = '0;
        in_if.wall_dist      = '0;
        in_if.line_height    = '0;
        in_if.draw_start     = '0;
        in_if.texel_addr     = '0;
        in_if.texel_color    = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.screen_height = SH_RESET;
        out_if.ready         = 1'b0;
        model_height         = SH_RESET;
        col_face             = FACE_NORTH;
        col_tex_x            = '0;
        col_dark             = 1'b0;
        tex_pos              = '0;
        tex_step             = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_random_phase(SH_W'(1), 0, 0, 60);
        test_random_phase('1, 45, 0, 60);
        test_random_phase(SH_W'($urandom_range(1, 4095)), 0, 45, 60);
        test_random_phase(SH_W'($urandom_range(1, 4095)), 33, 33, 60);
        test_output_backpressure();
        wait_idle();

        if (error_count == 0 && pending_pixels.size() == 0)
            $display("textured_wall_column regression: pass");
        else
            $display("textured_wall_column regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
